FILE: rtl/rlcp_pkg.sv
// ----------------------------------------------------------------------------
// rlcp_pkg: shared types and constants of the register log command parser
// Holds the event record, the parse phases, command codes and type mapping.
// ----------------------------------------------------------------------------
package rlcp_pkg;

  // Number of device type registers.
  localparam int NUM_DEVICES = 4;
  localparam int DEV_SEL_W   = $clog2(NUM_DEVICES);

  // Depth of the event queue between the parser and the output stage.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Length groups: counter saturates after the group at bit 35.
  localparam int GRP_W           = 3;
  localparam logic [2:0] GRP_LAST = 3'd5;
  localparam logic [5:0] GRP_BITS = 6'd7;

  // Configuration register indexes.
  localparam logic [2:0] REG_DEVICE_COUNT = 3'd0;
  localparam logic [2:0] REG_DEVICE_TYPE0 = 3'd1;

  // Command byte codes.
  localparam logic [7:0] CMD_WAIT_ONE = 8'hFF;
  localparam logic [7:0] CMD_WAIT_LEN = 8'hFE;
  localparam logic [7:0] CMD_END      = 8'hFD;

  // Chip kind used when no device is declared.
  localparam logic [1:0] DEFAULT_KIND = 2'd3;

  typedef enum logic [2:0] {
    EV_WAIT      = 3'd0,
    EV_WRITE     = 3'd1,
    EV_END       = 3'd2,
    EV_ERR_INDEX = 3'd3,
    EV_ERR_TYPE  = 3'd4
  } ev_kind_t;

  typedef enum logic [2:0] {
    PH_CMD,
    PH_LEN,
    PH_ADDR,
    PH_DATA,
    PH_STOP
  } phase_t;

  typedef struct packed {
    ev_kind_t    kind;
    logic [31:0] ticks;
    logic        port;
    logic [6:0]  dev;
    logic [1:0]  chip;
    logic [7:0]  addr;
    logic [7:0]  value;
  } ev_t;

  typedef struct packed {
    logic halted;
  } front_status_t;

  typedef struct packed {
    logic       bad;
    logic [1:0] kind;
  } kind_map_t;

  // Maps a raw device type code to a chip kind, flagging unmapped codes.
  function automatic kind_map_t map_type(input logic [7:0] code);
    kind_map_t m;
    m.bad  = 1'b0;
    m.kind = 2'd0;
    case (code)
      8'd0, 8'd1, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 8'd15: m.kind = 2'd0;
      8'd2: m.kind = 2'd1;
      8'd3: m.kind = 2'd2;
      8'd4: m.kind = 2'd3;
      default: m.bad = 1'b1;
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/register_log_command_parser.sv
// ----------------------------------------------------------------------------
// register_log_command_parser: sound-chip register log command parser
// Turns a byte stream of log commands into wait, write, end and error events.
// ----------------------------------------------------------------------------
//  channel  dir  contents
//  s_*      in   tdata[7:0] stream_byte
//  m_*      out  tuser event_kind; tdata tick_count, port_select, device_index,
//                chip_kind, reg_address, reg_value
//  cfg_*    in   write of device_count (0) or device_type_0..3 (1..4)
//
// One byte is taken every cycle while the queue has room; the event that a byte
// completes is written into the queue when that byte is taken, and the output
// register loads it from the queue once it is empty or its event is transferred.
// Reset returns the parser to the command phase and clears the device table.
// The four-entry event queue lets input continue while the output is stalled;
// input stalls only when the queue is full.
// After an end or error event, bytes are taken and dropped until reset.
module register_log_command_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] stream_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [31:0] tick_count, [32] port_select,
                                 // [39:33] device_index, [41:40] chip_kind,
                                 // [49:42] reg_address, [57:50] reg_value
  output logic [2:0]  m_tuser,   // [2:0] event_kind
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import rlcp_pkg::*;

  logic          q_push;
  ev_t           q_ev;
  logic          q_full;
  logic          q_pop;
  logic          q_avail;
  ev_t           q_head;
  front_status_t fr_status;

  rlcp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_byte  (s_tdata),
    .in_ready (s_tready),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .q_full   (q_full),
    .ev_push  (q_push),
    .ev       (q_ev),
    .status   (fr_status)
  );

  rlcp_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .push_ev(q_ev),
    .full   (q_full),
    .pop    (q_pop),
    .avail  (q_avail),
    .head   (q_head)
  );

  rlcp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_avail (q_avail),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  // The parser never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("event pushed into full queue");

  // Once stopped, the parser stays stopped until reset.
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    fr_status.halted |=> fr_status.halted)
    else $error("parser left the stopped phase");

  // End and error events stop the parser.
  a_halt_on_stop: assert property (@(posedge clk) disable iff (rst)
    q_push && (q_ev.kind == EV_END || q_ev.kind == EV_ERR_INDEX ||
               q_ev.kind == EV_ERR_TYPE) |=> fr_status.halted)
    else $error("stop event without halt");

  // Only wait events carry a tick count.
  a_ticks_wait_only: assert property (@(posedge clk) disable iff (rst)
    q_push && q_ev.kind != EV_WAIT |-> q_ev.ticks == 32'd0)
    else $error("tick count on a non-wait event");

endmodule

FILE: rtl/rlcp_front.sv
// ----------------------------------------------------------------------------
// rlcp_front: command byte parser
// Holds the device table, takes one byte per cycle while the queue has room and pushes events.
// ----------------------------------------------------------------------------
module rlcp_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [7:0]             in_byte,
  output logic                   in_ready,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [7:0]             cfg_data,
  input  logic                   q_full,
  output logic                   ev_push,
  output rlcp_pkg::ev_t          ev,
  output rlcp_pkg::front_status_t status
);
  import rlcp_pkg::*;

  phase_t           phase, phase_next;
  logic [31:0]      acc, acc_next;
  logic [GRP_W-1:0] grp, grp_next;
  logic [6:0]       held_device, held_device_next;
  logic             held_port, held_port_next;
  logic [1:0]       held_kind, held_kind_next;
  logic [7:0]       held_address, held_address_next;

  logic [2:0]       device_count;
  logic [7:0]       device_type [NUM_DEVICES];

  logic             accept;
  logic [2:0]       cnt_eff;
  logic             type_bad;
  logic [5:0]       shamt;
  logic [31:0]      group_wide;
  logic [31:0]      acc_sum;
  logic [6:0]       cmd_dev;
  kind_map_t        dev_map;

  // A byte transfer completes whenever the queue has room.
  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      device_count <= 3'd0;
      for (int i = 0; i < NUM_DEVICES; i++) begin
        device_type[i] <= 8'd0;
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_DEVICE_COUNT) begin
        device_count <= cfg_data[2:0];
      end else if (cfg_index >= REG_DEVICE_TYPE0 &&
                   cfg_index < REG_DEVICE_TYPE0 + 3'(NUM_DEVICES)) begin
        device_type[DEV_SEL_W'(cfg_index - REG_DEVICE_TYPE0)] <= cfg_data;
      end
    end
  end

  // Declared count saturates at the table size.
  assign cnt_eff = (device_count > 3'(NUM_DEVICES)) ? 3'(NUM_DEVICES) : device_count;

  // Any declared device with an unmapped type code stops the stream.
  always_comb begin
    kind_map_t slot_map;
    type_bad = 1'b0;
    for (int i = 0; i < NUM_DEVICES; i++) begin
      slot_map = map_type(device_type[i]);
      if (3'(i) < cnt_eff && slot_map.bad) begin
        type_bad = 1'b1;
      end
    end
  end

  // Length group placed at its 7-bit slot; bits beyond 32 fall away.
  assign shamt      = 6'(grp) * GRP_BITS;
  assign group_wide = 32'(in_byte[6:0]) << shamt;
  assign acc_sum    = acc | group_wide;

  assign cmd_dev = in_byte[7:1];
  assign dev_map = map_type(device_type[cmd_dev[DEV_SEL_W-1:0]]);

  // Phase and held fields.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_CMD;
      grp          <= '0;
      acc          <= '0;
      held_device  <= '0;
      held_port    <= 1'b0;
      held_kind    <= '0;
      held_address <= '0;
    end else begin
      phase        <= phase_next;
      grp          <= grp_next;
      acc          <= acc_next;
      held_device  <= held_device_next;
      held_port    <= held_port_next;
      held_kind    <= held_kind_next;
      held_address <= held_address_next;
    end
  end

  // Next phase and the event for the accepted byte.
  always_comb begin
    phase_next        = phase;
    acc_next          = acc;
    grp_next          = grp;
    held_device_next  = held_device;
    held_port_next    = held_port;
    held_kind_next    = held_kind;
    held_address_next = held_address;
    ev_push           = 1'b0;
    ev                = '0;
    ev.kind           = EV_WAIT;
    if (accept) begin
      case (phase)
        PH_CMD: begin
          if (type_bad) begin
            ev_push    = 1'b1;
            ev.kind    = EV_ERR_TYPE;
            phase_next = PH_STOP;
          end else if (in_byte == CMD_WAIT_ONE) begin
            ev_push  = 1'b1;
            ev.kind  = EV_WAIT;
            ev.ticks = 32'd1;
          end else if (in_byte == CMD_WAIT_LEN) begin
            acc_next   = 32'd0;
            grp_next   = '0;
            phase_next = PH_LEN;
          end else if (in_byte == CMD_END) begin
            ev_push    = 1'b1;
            ev.kind    = EV_END;
            phase_next = PH_STOP;
          end else if ((cnt_eff == 3'd0 && cmd_dev != 7'd0) ||
                       (cnt_eff != 3'd0 && cmd_dev >= 7'(cnt_eff))) begin
            ev_push    = 1'b1;
            ev.kind    = EV_ERR_INDEX;
            ev.port    = in_byte[0];
            ev.dev     = cmd_dev;
            phase_next = PH_STOP;
          end else begin
            held_kind_next   = (cnt_eff == 3'd0) ? DEFAULT_KIND : dev_map.kind;
            held_device_next = cmd_dev;
            held_port_next   = in_byte[0];
            phase_next       = PH_ADDR;
          end
        end
        PH_LEN: begin
          acc_next = acc_sum;
          if (in_byte[7]) begin
            if (grp != GRP_LAST) begin
              grp_next = grp + GRP_W'(1);
            end
          end else begin
            ev_push    = 1'b1;
            ev.kind    = EV_WAIT;
            ev.ticks   = acc_sum;
            grp_next   = '0;
            phase_next = PH_CMD;
          end
        end
        PH_ADDR: begin
          held_address_next = in_byte;
          phase_next        = PH_DATA;
        end
        PH_DATA: begin
          ev_push    = 1'b1;
          ev.kind    = EV_WRITE;
          ev.port    = held_port;
          ev.dev     = held_device;
          ev.chip    = held_kind;
          ev.addr    = held_address;
          ev.value   = in_byte;
          phase_next = PH_CMD;
        end
        default: begin
          phase_next = PH_STOP;
        end
      endcase
    end
  end

  assign status.halted = (phase == PH_STOP);

endmodule

FILE: rtl/rlcp_queue.sv
// ----------------------------------------------------------------------------
// rlcp_queue: event queue
// Short first-in first-out buffer between the parser and the output stage.
// ----------------------------------------------------------------------------
module rlcp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rlcp_pkg::ev_t push_ev,
  output logic          full,
  input  logic          pop,
  output logic          avail,
  output rlcp_pkg::ev_t head
);
  import rlcp_pkg::*;

  ev_t               slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign avail = (count != '0);
  assign head  = slots[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_ev;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/rlcp_back.sv
// ----------------------------------------------------------------------------
// rlcp_back: event output stage
// Takes events from the queue into the output register and packs them.
// ----------------------------------------------------------------------------
module rlcp_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_avail,
  input  rlcp_pkg::ev_t q_head,
  output logic          q_pop,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [63:0]   m_tdata,
  output logic [2:0]    m_tuser
);
  import rlcp_pkg::*;

  ev_t  out_ev;
  logic load;

  // Load when the register is empty or its event is being transferred.
  assign load  = q_avail && (!m_tvalid || m_tready);
  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ev <= q_head;
    end
  end

  // Pack fields from the lowest bit up.
  assign m_tdata = {6'd0, out_ev.value, out_ev.addr, out_ev.chip, out_ev.dev,
                    out_ev.port, out_ev.ticks};
  assign m_tuser = out_ev.kind;

endmodule

FILE: dv/register_log_command_parser_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// register_log_command_parser_tb: self-checking bench of the log command parser
// Streams command bytes through the parser under several device tables and
// compares every event with a cycle-free software copy of the parser.
// Random gaps on both sides, one long output stall and one terminal event
// (end, bad index or bad type, picked at random) close out the run.
// ----------------------------------------------------------------------------
module register_log_command_parser_tb;
  import rlcp_pkg::*;

  localparam int IDLE_LIMIT    = 3000;
  localparam int LONG_STALL    = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_BYTES   = 55;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = 8'd0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [63:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_index = 3'd0;
  logic [7:0]  cfg_data  = 8'd0;

  register_log_command_parser DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Bytes waiting to be sent and events waiting to come out.
  logic [7:0] cmd_bytes[$];
  ev_t        log_events[$];

  // Shadow copy of the device table and of the parse state.
  logic [2:0]  sh_count;
  logic [7:0]  sh_type [NUM_DEVICES];
  phase_t      sh_phase;
  logic [31:0] sh_len;
  logic [5:0]  sh_shift;
  logic [6:0]  sh_dev;
  logic        sh_port;
  logic [1:0]  sh_kind;
  logic [7:0]  sh_addr;

  // Transfer flags of the last rising edge, read by the drivers.
  bit in_fire;
  bit out_fire;
  int src_gap;
  int snk_gap;
  int stall_left;
  int stall_reqs;
  int stall_done;
  bit src_idle_on = 1'b1;
  bit snk_idle_on = 1'b1;
  int err_count;
  int idle_cycles;

  initial begin
    forever #10 clk = ~clk;
  end

  // Appends a byte to the send queue.
  function automatic void put_byte(input logic [7:0] b);
    cmd_bytes.insert(cmd_bytes.size(), b);
  endfunction

  // Appends an event to the expected queue.
  function automatic void put_event(input ev_t e);
    log_events.insert(log_events.size(), e);
  endfunction

  // Chip kind of a raw type code, or -1 when the code is not in the table.
  function automatic int chip_of(input logic [7:0] code);
    case (code)
      8'd0, 8'd1, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 8'd15: return 0;
      8'd2: return 1;
      8'd3: return 2;
      8'd4: return 3;
      default: return -1;
    endcase
  endfunction

  // Declared device count, saturated at the size of the table.
  function automatic int eff_count();
    return (sh_count > NUM_DEVICES) ? NUM_DEVICES : int'(sh_count);
  endfunction

  // Number of device indexes that a write may address.
  function automatic int dev_limit();
    return (eff_count() == 0) ? 1 : eff_count();
  endfunction

  function automatic ev_t make_ev(input ev_kind_t k, input logic [31:0] t, input logic p,
                                  input logic [6:0] d, input logic [1:0] c,
                                  input logic [7:0] a, input logic [7:0] v);
    ev_t e;
    e.kind  = k;
    e.ticks = t;
    e.port  = p;
    e.dev   = d;
    e.chip  = c;
    e.addr  = a;
    e.value = v;
    return e;
  endfunction

  function automatic string ev_text(input ev_t e);
    return $sformatf("kind=%0d ticks=%h port=%0d dev=%0d chip=%0d addr=%h value=%h",
                     e.kind, e.ticks, e.port, e.dev, e.chip, e.addr, e.value);
  endfunction

  // Advances the shadow parser by one byte and queues the event it causes.
  function automatic void parse_byte(input logic [7:0] b);
    int  cnt;
    bit  bad;
    cnt = eff_count();
    bad = 1'b0;
    case (sh_phase)
      PH_CMD: begin
        // A bad type among the declared devices halts before decoding.
        for (int i = 0; i < cnt; i++) begin
          if (chip_of(sh_type[i]) < 0) bad = 1'b1;
        end
        if (bad) begin
          sh_phase = PH_STOP;
          put_event(make_ev(EV_ERR_TYPE, '0, 1'b0, '0, '0, '0, '0));
        end else if (b == CMD_WAIT_ONE) begin
          put_event(make_ev(EV_WAIT, 32'd1, 1'b0, '0, '0, '0, '0));
        end else if (b == CMD_WAIT_LEN) begin
          sh_phase = PH_LEN;
          sh_len   = '0;
          sh_shift = '0;
        end else if (b == CMD_END) begin
          sh_phase = PH_STOP;
          put_event(make_ev(EV_END, '0, 1'b0, '0, '0, '0, '0));
        end else if (b[7:1] >= dev_limit()) begin
          sh_phase = PH_STOP;
          put_event(make_ev(EV_ERR_INDEX, '0, b[0], b[7:1], '0, '0, '0));
        end else begin
          sh_kind  = (cnt == 0) ? DEFAULT_KIND : 2'(chip_of(sh_type[b[2:1]]));
          sh_dev   = b[7:1];
          sh_port  = b[0];
          sh_phase = PH_ADDR;
        end
      end
      PH_LEN: begin
        // Groups past bit 31 are cut off; the shift stops at 35.
        if (sh_shift < 32) sh_len |= 32'(b[6:0]) << sh_shift;
        if (b[7]) begin
          sh_shift += 6'd7;
          if (sh_shift > 35) sh_shift = 6'd35;
        end else begin
          sh_phase = PH_CMD;
          sh_shift = '0;
          put_event(make_ev(EV_WAIT, sh_len, 1'b0, '0, '0, '0, '0));
        end
      end
      PH_ADDR: begin
        sh_addr  = b;
        sh_phase = PH_DATA;
      end
      PH_DATA: begin
        sh_phase = PH_CMD;
        put_event(make_ev(EV_WRITE, '0, sh_port, sh_dev, sh_kind, sh_addr, b));
      end
      default: ;
    endcase
  endfunction

  // Compares one output transfer with the oldest queued event.
  function automatic void check_event();
    ev_t got;
    ev_t want;
    got.kind  = ev_kind_t'(m_tuser);
    got.ticks = m_tdata[31:0];
    got.port  = m_tdata[32];
    got.dev   = m_tdata[39:33];
    got.chip  = m_tdata[41:40];
    got.addr  = m_tdata[49:42];
    got.value = m_tdata[57:50];
    if (log_events.size() == 0) begin
      err_count++;
      if (err_count <= 10) $display("unexpected event: %s", ev_text(got));
    end else begin
      want = log_events.pop_front();
      if (got.kind !== want.kind || got.ticks !== want.ticks || got.port !== want.port ||
          got.dev !== want.dev || got.chip !== want.chip || got.addr !== want.addr ||
          got.value !== want.value) begin
        err_count++;
        if (err_count <= 10) begin
          $display("event mismatch at %0t", $realtime);
          $display("  expected: %s", ev_text(want));
          $display("  actual:   %s", ev_text(got));
        end
      end
    end
  endfunction

  // Sampling at the rising edge: output check, input prediction, watchdog.
  always @(posedge clk) begin
    in_fire  = 1'b0;
    out_fire = 1'b0;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        out_fire = 1'b1;
        check_event();
      end
      if (s_tvalid && s_tready) begin
        in_fire = 1'b1;
        parse_byte(s_tdata);
      end
    end
    if (rst || in_fire || out_fire) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("[register_log_command_parser] ERROR");
        $finish;
      end
    end
  end

  // Byte driver: takes the next byte from the queue after a random gap.
  always @(negedge clk) begin : drive_bytes
    logic       nv;
    logic [7:0] nd;
    nv = s_tvalid;
    nd = s_tdata;
    if (rst) begin
      nv = 1'b0;
    end else if (!s_tvalid || in_fire) begin
      if (src_gap > 0) begin
        src_gap--;
        nv = 1'b0;
      end else if (cmd_bytes.size() != 0) begin
        nd      = cmd_bytes.pop_front();
        nv      = 1'b1;
        src_gap = src_idle_on ? $urandom_range(0, 19) : 0;
      end else begin
        nv = 1'b0;
      end
    end
    s_tvalid <= nv;
    s_tdata  <= nd;
  end

  // Event sink: random wait per event, plus a long stall on request.
  always @(negedge clk) begin : drive_ready
    logic nr;
    nr = 1'b0;
    if (!rst) begin
      if (out_fire) snk_gap = snk_idle_on ? $urandom_range(0, 19) : 0;
      if (stall_left > 0) begin
        stall_left--;
      end else if (stall_reqs != stall_done) begin
        stall_done++;
        stall_left = LONG_STALL;
      end else if (snk_gap > 0) begin
        snk_gap--;
      end else begin
        nr = 1'b1;
      end
    end
    m_tready <= nr;
  end

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_DEVICE_COUNT) sh_count = val[2:0];
    else sh_type[2'(idx - REG_DEVICE_TYPE0)] = val;
  endtask

  // Waits until every byte is taken and every event has come out.
  task automatic wait_drained();
    while (cmd_bytes.size() != 0 || s_tvalid || log_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Address or data byte, often one that looks like a command code.
  function automatic logic [7:0] pick_payload();
    case ($urandom_range(0, 9))
      0: return CMD_WAIT_ONE;
      1: return CMD_WAIT_LEN;
      2: return CMD_END;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_length(input int groups);
    put_byte(CMD_WAIT_LEN);
    for (int g = 0; g < groups; g++) begin
      put_byte({1'(g != groups - 1), 7'($urandom_range(0, 127))});
    end
  endtask

  task automatic add_write();
    put_byte({7'($urandom_range(0, dev_limit() - 1)), 1'($urandom_range(0, 1))});
    put_byte(pick_payload());
    put_byte(pick_payload());
  endtask

  // Well-formed commands with random content; long lengths as the odd ones.
  task automatic add_traffic(input int n);
    int r;
    while (cmd_bytes.size() < n) begin
      r = $urandom_range(0, 99);
      if (r < 45) add_write();
      else if (r < 70) put_byte(CMD_WAIT_ONE);
      else if (r < 93) add_length($urandom_range(1, 3));
      else add_length($urandom_range(5, 9));
    end
  endtask

  // One setting of the device table followed by random traffic.
  task automatic run_phase(input logic [2:0] count, input logic [7:0] t0, input logic [7:0] t1,
                           input logic [7:0] t2, input logic [7:0] t3, input bit stall);
    write_reg(REG_DEVICE_COUNT, {5'($urandom_range(0, 31)), count});
    write_reg(REG_DEVICE_TYPE0, t0);
    write_reg(REG_DEVICE_TYPE0 + 3'd1, t1);
    write_reg(REG_DEVICE_TYPE0 + 3'd2, t2);
    write_reg(REG_DEVICE_TYPE0 + 3'd3, t3);
    src_idle_on = stall ? 1'b0 : ($urandom_range(0, 3) != 0);
    snk_idle_on = ($urandom_range(0, 3) != 0);
    if (stall) stall_reqs++;
    add_traffic(PHASE_BYTES);
    wait_drained();
  endtask

  function automatic logic [7:0] valid_type();
    int r;
    r = $urandom_range(0, 10);
    return (r == 10) ? 8'd15 : 8'(r);
  endfunction

  initial begin : main_flow
    logic [7:0] directed [25];
    int         term;
    int         bad_dev;
    logic [7:0] bad_code;
    directed = '{CMD_WAIT_ONE,
                 CMD_WAIT_LEN, 8'h00,
                 CMD_WAIT_LEN, 8'h80, 8'h80, 8'h80, 8'h80, 8'h08,
                 CMD_WAIT_LEN, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F,
                 8'h00, 8'h00, 8'h00,
                 8'h01, 8'hFF, 8'hFF,
                 8'h00, CMD_END, CMD_WAIT_LEN};
    sh_count = '0;
    foreach (sh_type[i]) sh_type[i] = '0;
    sh_phase = PH_CMD;
    sh_len   = '0;
    sh_shift = '0;
    sh_dev   = '0;
    sh_port  = 1'b0;
    sh_kind  = '0;
    sh_addr  = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed bytes on the reset table: one default device of kind 3.
    foreach (directed[i]) put_byte(directed[i]);
    wait_drained();

    // Table settings, extremes of count and type codes among them.
    run_phase(3'd4, 8'd2, 8'd3, 8'd4, 8'd15, 1'b1);
    run_phase(3'd1, 8'd0, 8'd255, 8'd128, 8'd127, 1'b0);
    run_phase(3'd7, 8'd1, 8'd5, 8'd9, 8'd8, 1'b0);
    run_phase(3'd2, 8'd6, 8'd7, 8'hAA, 8'h55, 1'b0);
    run_phase(3'd0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0);
    run_phase(3'd3, valid_type(), valid_type(), valid_type(), 8'($urandom_range(0, 255)), 1'b0);
    run_phase(3'd5, valid_type(), valid_type(), valid_type(), valid_type(), 1'b0);

    // One terminal event, then bytes that the halted parser must drop.
    term = $urandom_range(0, 2);
    case (term)
      0: put_byte(CMD_END);
      1: put_byte(8'($urandom_range(2 * dev_limit(), 8'hFC)));
      default: begin
        bad_dev  = $urandom_range(0, NUM_DEVICES - 1);
        bad_code = $urandom_range(0, 1) ? 8'($urandom_range(16, 255)) :
                                          8'($urandom_range(10, 14));
        write_reg(REG_DEVICE_COUNT, 8'($urandom_range(bad_dev + 1, 7)));
        write_reg(REG_DEVICE_TYPE0 + 3'(bad_dev), bad_code);
        put_byte(8'($urandom_range(0, 255)));
      end
    endcase
    repeat (12) put_byte(8'($urandom_range(0, 255)));
    wait_drained();
    repeat (20) @(posedge clk);

    if (log_events.size() != 0) begin
      err_count += log_events.size();
      $display("%0d events never arrived, first: %s", log_events.size(),
               ev_text(log_events[0]));
    end
    if (err_count == 0) begin
      $display("[register_log_command_parser] OK");
    end else begin
      $display("[register_log_command_parser] ERROR");
    end
    $finish;
  end

endmodule
